// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the route engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold expr at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

// hold cons in the same cycle as ante
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// hold cons in the cycle after ante
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/iflpm_pkg.sv =====
// ----------------------------------------------------------------------------
// iflpm_pkg
// Types, codes and helpers shared by the IPv4 route engine modules.
// ----------------------------------------------------------------------------
package iflpm_pkg;

    localparam int ROUTE_ENTRIES = 64;
    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_FWD   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [2:0] VERDICT_LOCAL   = 3'd0;
    localparam logic [2:0] VERDICT_FWD     = 3'd1;
    localparam logic [2:0] VERDICT_TTL     = 3'd2;
    localparam logic [2:0] VERDICT_NOROUTE = 3'd3;
    localparam logic [2:0] VERDICT_ADDED   = 3'd4;
    localparam logic [2:0] VERDICT_FULL    = 3'd5;
    localparam logic [2:0] VERDICT_CLEARED = 3'd6;

    localparam logic [5:0] MAX_LEN = 6'd32;
    localparam logic [3:0] CSUM_WORDS = 4'd9;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] hdr_front;
        logic [63:0] hdr_middle;
        logic [31:0] hdr_dest;
        logic [31:0] route_prefix;
        logic [5:0]  route_masklen;
        logic [31:0] route_hop;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] next_hop;
        logic [7:0]  new_ttl;
        logic [15:0] new_checksum;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } sts_t;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
            m = 32'h0;
        else if (len >= MAX_LEN)
            m = 32'hffffffff;
        else
            m = 32'hffffffff << (MAX_LEN - len);
        return m;
    endfunction

endpackage

// ===== rtl/iflpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// iflpm_ctrl
// Sequencer for the route engine: accept, table scan, drain, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iflpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_req_type,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output iflpm_pkg::cmd_t     cmd,
    input  iflpm_pkg::sts_t     sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = accept;
    assign cmd.step   = (state_reg == ST_SCAN);
    assign cmd.finish = (state_reg == ST_FINISH) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_req_type == iflpm_pkg::REQ_CLEAR)
                        state_next = ST_FINISH;
                    else if (in_req_type == iflpm_pkg::REQ_NONE)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CHK_IMPLY(a_finish_slot_free, clk, rst_n, cmd.finish, !out_valid_reg || !out_stall)
    `CHK_NEXT(a_finish_shows_word, clk, rst_n, cmd.finish, out_valid_reg && state_reg == ST_IDLE)
    `CHK_IMPLY(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !cmd.load)

endmodule

// ===== rtl/iflpm_dp.sv =====
// ----------------------------------------------------------------------------
// iflpm_dp
// Route table memory, scan evaluation, checksum accumulator, result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iflpm_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iflpm_pkg::in_word_t   in_data,
    input  logic                  cfg_write,
    input  logic [31:0]           cfg_data,
    input  iflpm_pkg::cmd_t       cmd,
    output iflpm_pkg::sts_t       sts,
    output iflpm_pkg::out_word_t  out_data
);

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [31:0] hop;
    } entry_t;

    localparam logic [iflpm_pkg::IDX_W-1:0] LAST_IDX =
        iflpm_pkg::IDX_W'(iflpm_pkg::ROUTE_ENTRIES - 1);

    entry_t mem [iflpm_pkg::ROUTE_ENTRIES];

    logic [iflpm_pkg::ROUTE_ENTRIES-1:0] valid_reg;
    logic [31:0]                         local_reg;

    logic [1:0]                  req_reg;
    logic [63:0]                 front_reg;
    logic [63:0]                 middle_reg;
    logic [31:0]                 dest_reg;
    logic [31:0]                 pfx_reg;
    logic [5:0]                  len_reg;
    logic [31:0]                 hop_reg;

    logic [iflpm_pkg::IDX_W-1:0] idx_reg;
    logic [3:0]                  csum_cnt_reg;
    logic [19:0]                 acc_reg;

    entry_t                      rd_data_reg;
    logic                        rd_vbit_reg;
    logic [iflpm_pkg::IDX_W-1:0] rd_idx_reg;
    logic                        eval_en_reg;

    logic                        dup_reg;
    logic                        free_found_reg;
    logic [iflpm_pkg::IDX_W-1:0] free_idx_reg;
    logic                        best_found_reg;
    logic [5:0]                  best_len_reg;
    logic [31:0]                 best_hop_reg;

    iflpm_pkg::out_word_t        out_data_reg;
    iflpm_pkg::out_word_t        out_data_next;

    logic [5:0]  len_sat;
    logic [7:0]  ttl_in;
    logic [7:0]  ttl_dec;
    logic [15:0] csum_word;
    logic        idx_last;
    logic        csum_run;
    logic        hit;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic        do_write;

    assign len_sat  = (in_data.route_masklen > iflpm_pkg::MAX_LEN) ?
                      iflpm_pkg::MAX_LEN : in_data.route_masklen;
    assign ttl_in   = middle_reg[63:56];
    assign ttl_dec  = ttl_in - 8'd1;
    assign idx_last = (idx_reg == LAST_IDX);
    assign csum_run = (csum_cnt_reg < iflpm_pkg::CSUM_WORDS);

    assign sts.scan_done = cmd.step && idx_last && (csum_cnt_reg >= (iflpm_pkg::CSUM_WORDS - 4'd1));

    always_comb
    begin
        unique case (csum_cnt_reg)
            4'd0:    csum_word = front_reg[63:48];
            4'd1:    csum_word = front_reg[47:32];
            4'd2:    csum_word = front_reg[31:16];
            4'd3:    csum_word = front_reg[15:0];
            4'd4:    csum_word = {ttl_dec, middle_reg[55:48]};
            4'd5:    csum_word = middle_reg[31:16];
            4'd6:    csum_word = middle_reg[15:0];
            4'd7:    csum_word = dest_reg[31:16];
            4'd8:    csum_word = dest_reg[15:0];
            default: csum_word = 16'h0;
        endcase
    end

    assign hit = rd_vbit_reg &&
                 ((dest_reg & iflpm_pkg::mask_of(rd_data_reg.length)) == rd_data_reg.prefix) &&
                 (!best_found_reg || (rd_data_reg.length > best_len_reg));

    assign fold1 = {1'b0, acc_reg[15:0]} + {13'b0, acc_reg[19:16]};
    assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

    assign do_write = cmd.finish && (req_reg == iflpm_pkg::REQ_ADD) &&
                      !dup_reg && free_found_reg;

    always_comb
    begin
        out_data_next.verdict      = iflpm_pkg::VERDICT_ADDED;
        out_data_next.next_hop     = 32'h0;
        out_data_next.new_ttl      = ttl_in;
        out_data_next.new_checksum = middle_reg[47:32];
        unique case (req_reg)
            iflpm_pkg::REQ_ADD:
            begin
                if (!dup_reg && !free_found_reg)
                    out_data_next.verdict = iflpm_pkg::VERDICT_FULL;
            end
            iflpm_pkg::REQ_FWD:
            begin
                priority if (dest_reg == local_reg)
                    out_data_next.verdict = iflpm_pkg::VERDICT_LOCAL;
                else if (ttl_in == 8'd0)
                    out_data_next.verdict = iflpm_pkg::VERDICT_TTL;
                else if (!best_found_reg)
                    out_data_next.verdict = iflpm_pkg::VERDICT_NOROUTE;
                else
                begin
                    out_data_next.verdict      = iflpm_pkg::VERDICT_FWD;
                    out_data_next.next_hop     = best_hop_reg;
                    out_data_next.new_ttl      = ttl_dec;
                    out_data_next.new_checksum = ~fold2;
                end
            end
            iflpm_pkg::REQ_CLEAR:
                out_data_next.verdict = iflpm_pkg::VERDICT_CLEARED;
            default:
                out_data_next.verdict = iflpm_pkg::VERDICT_CLEARED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            local_reg      <= 32'h0;
            eval_en_reg    <= 1'b0;
            idx_reg        <= '0;
            csum_cnt_reg   <= 4'd0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                local_reg <= cfg_data;
            eval_en_reg <= cmd.step;
            if (cmd.load)
            begin
                idx_reg        <= '0;
                csum_cnt_reg   <= 4'd0;
                dup_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step && !idx_last)
                    idx_reg <= idx_reg + 1'b1;
                if (cmd.step && csum_run)
                    csum_cnt_reg <= csum_cnt_reg + 4'd1;
                if (eval_en_reg)
                begin
                    if (rd_vbit_reg && (rd_data_reg.prefix == pfx_reg) &&
                        (rd_data_reg.length == len_reg))
                        dup_reg <= 1'b1;
                    if (!rd_vbit_reg && !free_found_reg)
                        free_found_reg <= 1'b1;
                    if (hit)
                        best_found_reg <= 1'b1;
                end
            end
            if (cmd.finish && (req_reg == iflpm_pkg::REQ_CLEAR))
                valid_reg <= '0;
            else if (do_write)
                valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= in_data.req_type;
            front_reg  <= in_data.hdr_front;
            middle_reg <= in_data.hdr_middle;
            dest_reg   <= in_data.hdr_dest;
            pfx_reg    <= in_data.route_prefix & iflpm_pkg::mask_of(len_sat);
            len_reg    <= len_sat;
            hop_reg    <= in_data.route_hop;
            acc_reg    <= 20'h0;
        end
        else if (cmd.step && csum_run)
            acc_reg <= acc_reg + {4'b0, csum_word};
        if (cmd.step)
        begin
            rd_data_reg <= mem[idx_reg];
            rd_vbit_reg <= valid_reg[idx_reg];
            rd_idx_reg  <= idx_reg;
        end
        if (eval_en_reg && !cmd.load)
        begin
            if (!rd_vbit_reg && !free_found_reg)
                free_idx_reg <= rd_idx_reg;
            if (hit)
            begin
                best_len_reg <= rd_data_reg.length;
                best_hop_reg <= rd_data_reg.hop;
            end
        end
        if (do_write)
            mem[free_idx_reg] <= '{prefix: pfx_reg, length: len_reg, hop: hop_reg};
        if (cmd.finish)
            out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

    `CHK_IMPLY(a_write_free_slot, clk, rst_n, do_write, !valid_reg[free_idx_reg])
    `CHK_IMPLY(a_best_len_range, clk, rst_n, best_found_reg, best_len_reg <= iflpm_pkg::MAX_LEN)
    `CHK_IMPLY(a_step_after_load, clk, rst_n, cmd.load, !cmd.step && !cmd.finish)

endmodule

// ===== rtl/ipv4_forward_lpm_engine.sv =====
// ----------------------------------------------------------------------------
// ipv4_forward_lpm_engine
// Each request word is an add-route, forward-header or clear-table request and
// yields one result word; code 3 is taken and yields nothing. An add or a
// forward scans the route table in order through its single memory read port,
// one entry per cycle, then drains; a finish state registers the result. The
// header checksum is summed during the scan and folded at the end. A clear goes
// straight to the finish state. The engine works on one request at a time; the
// next request is taken while the previous result still waits in the output
// register. local_address is written through the configuration port, which is
// always ready; the user must do so only while the engine is idle, unenforced.
// ----------------------------------------------------------------------------
module ipv4_forward_lpm_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  iflpm_pkg::in_word_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output iflpm_pkg::out_word_t  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);

    iflpm_pkg::cmd_t cmd;
    iflpm_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    iflpm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_req_type (in_data.req_type),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    iflpm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule
